// ===== rtl/nsdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Netstring deframer package
// Shared constants, result codes and the result word type of the deframer.
// ----------------------------------------------------------------------------
package nsdf_pkg;

   localparam int LENGTH_BITS_DEF = 16;

   localparam logic [15:0] MAX_LENGTH_RESET = 16'd32766;
   localparam logic        MODE_RESET       = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_MODE    = 1'b0;
   localparam logic CSR_MAX_LEN = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_BADCHAR = 3'd1;
   localparam logic [2:0] ERR_ZERO    = 3'd2;
   localparam logic [2:0] ERR_LONG    = 3'd3;
   localparam logic [2:0] ERR_TERM    = 3'd4;

   // Characters of the framing.
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_COMMA = 8'h2c;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload;
      logic       last;
      logic [2:0] error_code;
   } nsdf_result_type;

endpackage

// ===== rtl/netstring_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Netstring deframer core
// Decodes length-prefixed netstring frames from a byte stream, or passes
// receive chunks through unchanged in raw mode.
// ----------------------------------------------------------------------------
// A result is registered in the output register, or in the skid entry while the output is stalled.
// One word is taken per cycle while req_stall is low.
// A two-entry output buffer lets the input keep flowing for one word while a
// result is stalled; req_stall rises only once both entries are full.
// Reset (synchronous): netstring mode on, max_length 32766, decoder idle.
module netstring_deframer_core #(
   parameter int LENGTH_BITS = nsdf_pkg::LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_chunk_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload,
   output logic        rsp_last,
   output logic [2:0]  rsp_error_code,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int CalcW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 4;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEN,
      PH_PAY,
      PH_TERM,
      PH_DROP
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [LENGTH_BITS-1:0]    len_ff, len_in;
   logic                      mode_ff;
   logic [15:0]               max_len_ff;

   logic                      rsp_valid_ff;
   nsdf_pkg::nsdf_result_type rsp_ff;
   logic                      skid_valid_ff;
   nsdf_pkg::nsdf_result_type skid_ff;

   logic                      accept;
   logic                      has_result;
   nsdf_pkg::nsdf_result_type result;

   logic                      is_digit;
   logic                      is_space;
   logic [3:0]                digit_val;
   logic [CalcW-1:0]          limit;
   logic [CalcW-1:0]          max_len_w;
   logic [CalcW-1:0]          cap_w;
   logic [CalcW-1:0]          len_w;
   logic [CalcW-1:0]          len_next_w;
   logic [CalcW-1:0]          digit_w;
   logic [LENGTH_BITS-1:0]    len_dec;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   assign is_digit  = (req_data_byte >= nsdf_pkg::CH_ZERO) &&
                      (req_data_byte <= nsdf_pkg::CH_NINE);
   assign is_space  = (req_data_byte == nsdf_pkg::CH_SPACE) ||
                      (req_data_byte == nsdf_pkg::CH_TAB) ||
                      (req_data_byte == nsdf_pkg::CH_CR) ||
                      (req_data_byte == nsdf_pkg::CH_LF);
   assign digit_val = 4'(req_data_byte - nsdf_pkg::CH_ZERO);

   // The limit in force is max_length capped at the largest count the
   // length register can hold.
   assign max_len_w = CalcW'(max_len_ff);
   assign cap_w     = CalcW'({LENGTH_BITS{1'b1}});
   assign limit     = (max_len_w < cap_w) ? max_len_w : cap_w;

   assign len_w      = CalcW'(len_ff);
   assign digit_w    = CalcW'(digit_val);
   assign len_next_w = (len_w << 3) + (len_w << 1) + digit_w;
   assign len_dec    = len_ff - LENGTH_BITS'(1);

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      has_result = 1'b0;
      result     = '{kind: nsdf_pkg::KIND_BYTE, payload: 8'd0, last: 1'b0,
                     error_code: nsdf_pkg::ERR_NONE};
      if (!mode_ff) begin
         has_result     = 1'b1;
         result.payload = req_data_byte;
         result.last    = req_chunk_end;
      end else begin
         unique case (phase_ff)
            PH_LEN: begin
               if (is_digit) begin
                  if (len_next_w > limit) begin
                     has_result        = 1'b1;
                     result.kind       = nsdf_pkg::KIND_ERROR;
                     result.error_code = nsdf_pkg::ERR_LONG;
                  end else begin
                     len_in = LENGTH_BITS'(len_next_w);
                  end
               end else if (req_data_byte == nsdf_pkg::CH_COLON) begin
                  if (len_ff == '0) begin
                     has_result        = 1'b1;
                     result.kind       = nsdf_pkg::KIND_ERROR;
                     result.error_code = nsdf_pkg::ERR_ZERO;
                  end else begin
                     phase_in = PH_PAY;
                  end
               end else begin
                  has_result        = 1'b1;
                  result.kind       = nsdf_pkg::KIND_ERROR;
                  result.error_code = nsdf_pkg::ERR_BADCHAR;
               end
            end
            PH_PAY: begin
               len_in         = len_dec;
               has_result     = 1'b1;
               result.payload = req_data_byte;
               if (len_dec == '0) begin
                  phase_in = PH_TERM;
               end
            end
            PH_TERM: begin
               has_result = 1'b1;
               if (req_data_byte == nsdf_pkg::CH_COMMA) begin
                  phase_in    = PH_IDLE;
                  len_in      = '0;
                  result.kind = nsdf_pkg::KIND_ACCEPT;
               end else begin
                  result.kind       = nsdf_pkg::KIND_ERROR;
                  result.error_code = nsdf_pkg::ERR_TERM;
               end
            end
            PH_DROP: begin
               if (req_chunk_end) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               // Idle, and any unused phase code behaves as idle.
               phase_in = PH_IDLE;
               if (is_space) begin
                  has_result = 1'b0;
               end else if (is_digit) begin
                  if (digit_w > limit) begin
                     has_result        = 1'b1;
                     result.kind       = nsdf_pkg::KIND_ERROR;
                     result.error_code = nsdf_pkg::ERR_LONG;
                  end else begin
                     len_in   = LENGTH_BITS'(digit_val);
                     phase_in = PH_LEN;
                  end
               end else if (req_data_byte == nsdf_pkg::CH_COLON) begin
                  has_result        = 1'b1;
                  result.kind       = nsdf_pkg::KIND_ERROR;
                  result.error_code = nsdf_pkg::ERR_ZERO;
               end else begin
                  has_result        = 1'b1;
                  result.kind       = nsdf_pkg::KIND_ERROR;
                  result.error_code = nsdf_pkg::ERR_BADCHAR;
               end
            end
         endcase
         // Any error drops the rest of the chunk.
         if (has_result && result.kind == nsdf_pkg::KIND_ERROR) begin
            phase_in = req_chunk_end ? PH_IDLE : PH_DROP;
            len_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         len_ff        <= '0;
         mode_ff       <= nsdf_pkg::MODE_RESET;
         max_len_ff    <= nsdf_pkg::MAX_LENGTH_RESET;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               nsdf_pkg::CSR_MODE: begin
                  mode_ff  <= csr_write_data[0];
                  phase_ff <= PH_IDLE;
                  len_ff   <= '0;
               end
               nsdf_pkg::CSR_MAX_LEN: begin
                  max_len_ff <= csr_write_data;
               end
            endcase
         end else if (accept && mode_ff) begin
            phase_ff <= phase_in;
            len_ff   <= len_in;
         end

         // Output side: the skid entry refills the output register first.
         if (!rsp_stall && skid_valid_ff) begin
            rsp_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else if (accept && has_result) begin
            if (rsp_valid_ff && rsp_stall) begin
               skid_ff       <= result;
               skid_valid_ff <= 1'b1;
            end else begin
               rsp_ff       <= result;
               rsp_valid_ff <= 1'b1;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_payload    = rsp_ff.payload;
   assign rsp_last       = rsp_ff.last;
   assign rsp_error_code = rsp_ff.error_code;

   // The skid entry is only ever filled behind a waiting output word.
   a_skid_behind_output : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds a word while the output is empty");

   // While payload bytes are being passed, some are still owed.
   a_pay_count_nonzero : assert property (@(posedge clock) disable iff (reset)
      (mode_ff && phase_ff == PH_PAY) |-> (len_ff != '0))
      else $error("payload phase with a zero remaining count");

   // Error codes appear only on error results.
   a_code_on_error : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind != nsdf_pkg::KIND_ERROR) |->
         (rsp_ff.error_code == nsdf_pkg::ERR_NONE))
      else $error("error code set on a non-error result");

   // An error result sends the decoder to drop or idle.
   a_error_leaves_frame : assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff && !csr_write_enable && has_result &&
       result.kind == nsdf_pkg::KIND_ERROR) |=>
         (phase_ff == PH_DROP || phase_ff == PH_IDLE))
      else $error("decoder stayed inside a frame after an error");

   // A stalled result word holds still until it is taken.
   a_rsp_held_while_stalled : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("result word changed while stalled");

endmodule

// ===== tb/sv/netstring_deframer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Netstring deframer core testbench
// Drives byte words into the deframer and checks every result word against
// a cycle-free decoder written here. A short table of directed words comes
// first. Random netstring frames, broken frames, noise and raw chunks follow
// under several register settings, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module netstring_deframer_core_tb;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned LONG_HOLD_CYCLES = 200;

   typedef enum logic [2:0] {
      DEC_IDLE,
      DEC_LENGTH,
      DEC_PAYLOAD,
      DEC_TERM,
      DEC_DROP
   } dec_phase_type;

   typedef struct packed {
      logic [7:0]                data;
      logic                      chunk_end;
      logic                      typed;
      logic                      has_result;
      nsdf_pkg::nsdf_result_type result;
   } stim_row_type;

   localparam nsdf_pkg::nsdf_result_type NO_RESULT = '0;
   localparam int DIRECTED_COUNT = 26;

   // A frame of length two whose header ends a chunk, then the error cases.
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{nsdf_pkg::CH_SPACE, 1'b0, 1'b1, 1'b0, NO_RESULT},
      '{nsdf_pkg::CH_TAB, 1'b0, 1'b1, 1'b0, NO_RESULT},
      '{nsdf_pkg::CH_CR, 1'b0, 1'b1, 1'b0, NO_RESULT},
      '{nsdf_pkg::CH_LF, 1'b0, 1'b1, 1'b0, NO_RESULT},
      '{8'h32, 1'b0, 1'b1, 1'b0, NO_RESULT},
      '{nsdf_pkg::CH_COLON, 1'b1, 1'b1, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b1, 1'b1,
        '{nsdf_pkg::KIND_BYTE, 8'h00, 1'b0, nsdf_pkg::ERR_NONE}},
      '{8'hff, 1'b1, 1'b1, 1'b1,
        '{nsdf_pkg::KIND_BYTE, 8'hff, 1'b0, nsdf_pkg::ERR_NONE}},
      '{nsdf_pkg::CH_COMMA, 1'b0, 1'b1, 1'b1,
        '{nsdf_pkg::KIND_ACCEPT, 8'h00, 1'b0, nsdf_pkg::ERR_NONE}},
      '{nsdf_pkg::CH_COLON, 1'b1, 1'b1, 1'b1,
        '{nsdf_pkg::KIND_ERROR, 8'h00, 1'b0, nsdf_pkg::ERR_ZERO}},
      '{nsdf_pkg::CH_ZERO, 1'b0, 1'b1, 1'b0, NO_RESULT},
      '{nsdf_pkg::CH_COLON, 1'b0, 1'b1, 1'b1,
        '{nsdf_pkg::KIND_ERROR, 8'h00, 1'b0, nsdf_pkg::ERR_ZERO}},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RESULT},
      '{8'hff, 1'b1, 1'b1, 1'b0, NO_RESULT},
      '{8'h61, 1'b1, 1'b1, 1'b1,
        '{nsdf_pkg::KIND_ERROR, 8'h00, 1'b0, nsdf_pkg::ERR_BADCHAR}},
      '{8'h31, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h3b, 1'b1, 1'b1, 1'b1,
        '{nsdf_pkg::KIND_ERROR, 8'h00, 1'b0, nsdf_pkg::ERR_BADCHAR}},
      '{8'h33, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h32, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h37, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h36, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h37, 1'b1, 1'b1, 1'b1,
        '{nsdf_pkg::KIND_ERROR, 8'h00, 1'b0, nsdf_pkg::ERR_LONG}},
      '{8'h31, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{nsdf_pkg::CH_COLON, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h5a, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h2e, 1'b1, 1'b1, 1'b1,
        '{nsdf_pkg::KIND_ERROR, 8'h00, 1'b0, nsdf_pkg::ERR_TERM}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_chunk_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_payload;
   logic        rsp_last;
   logic [2:0]  rsp_error_code;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = nsdf_pkg::CSR_MODE;
   logic [15:0] csr_write_data = 16'h0000;

   // Decoder state and register copies kept by the testbench.
   logic          cfg_netstring = nsdf_pkg::MODE_RESET;
   logic [15:0]   cfg_max_length = nsdf_pkg::MAX_LENGTH_RESET;
   dec_phase_type dec_phase = DEC_IDLE;
   logic [15:0]   dec_count = 16'h0000;

   nsdf_pkg::nsdf_result_type pending_results [$];
   int unsigned     sent_words = 0;
   int unsigned     mismatches = 0;
   int unsigned     cycle_count = 0;
   int unsigned     hold_requests = 0;
   bit              tx_idle_on = 1'b1;
   bit              rx_idle_on = 1'b1;
   bit              idle_allowed = 1'b1;

   netstring_deframer_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_chunk_end    (req_chunk_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload      (rsp_payload),
      .rsp_last         (rsp_last),
      .rsp_error_code   (rsp_error_code),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("netstring_deframer_core_tb: FAIL");
         $finish;
      end
   end

   function automatic nsdf_pkg::nsdf_result_type raise_error(input logic [2:0] code,
                                                             input logic e);
      nsdf_pkg::nsdf_result_type r;
      r = '0;
      r.kind = nsdf_pkg::KIND_ERROR;
      r.error_code = code;
      // An error on a chunk-ending word leaves nothing to drop.
      dec_phase = e ? DEC_IDLE : DEC_DROP;
      dec_count = '0;
      return r;
   endfunction

   // Advances the decoder by one word; returns 1 when the word yields a result.
   function automatic bit decode_word(input logic [7:0] b, input logic e,
                                      output nsdf_pkg::nsdf_result_type r);
      bit          digit;
      int unsigned value;
      r = '0;
      digit = (b >= nsdf_pkg::CH_ZERO) && (b <= nsdf_pkg::CH_NINE);
      if (!cfg_netstring) begin
         r.kind = nsdf_pkg::KIND_BYTE;
         r.payload = b;
         r.last = e;
         return 1'b1;
      end
      case (dec_phase)
         DEC_LENGTH: begin
            if (digit) begin
               value = dec_count * 32'd10 + 32'(b - nsdf_pkg::CH_ZERO);
               if (value > cfg_max_length) begin
                  r = raise_error(nsdf_pkg::ERR_LONG, e);
                  return 1'b1;
               end
               dec_count = value[15:0];
               return 1'b0;
            end
            if (b == nsdf_pkg::CH_COLON) begin
               if (dec_count == 0) begin
                  r = raise_error(nsdf_pkg::ERR_ZERO, e);
                  return 1'b1;
               end
               dec_phase = DEC_PAYLOAD;
               return 1'b0;
            end
            r = raise_error(nsdf_pkg::ERR_BADCHAR, e);
            return 1'b1;
         end
         DEC_PAYLOAD: begin
            dec_count = dec_count - 16'd1;
            if (dec_count == 0) dec_phase = DEC_TERM;
            r.kind = nsdf_pkg::KIND_BYTE;
            r.payload = b;
            return 1'b1;
         end
         DEC_TERM: begin
            if (b != nsdf_pkg::CH_COMMA) begin
               r = raise_error(nsdf_pkg::ERR_TERM, e);
               return 1'b1;
            end
            dec_phase = DEC_IDLE;
            dec_count = '0;
            r.kind = nsdf_pkg::KIND_ACCEPT;
            return 1'b1;
         end
         DEC_DROP: begin
            if (e) dec_phase = DEC_IDLE;
            return 1'b0;
         end
         default: begin
            dec_phase = DEC_IDLE;
            if (b == nsdf_pkg::CH_SPACE || b == nsdf_pkg::CH_TAB ||
                b == nsdf_pkg::CH_CR || b == nsdf_pkg::CH_LF) begin
               return 1'b0;
            end
            if (digit) begin
               value = 32'(b - nsdf_pkg::CH_ZERO);
               if (value > cfg_max_length) begin
                  r = raise_error(nsdf_pkg::ERR_LONG, e);
                  return 1'b1;
               end
               dec_count = value[15:0];
               dec_phase = DEC_LENGTH;
               return 1'b0;
            end
            if (b == nsdf_pkg::CH_COLON) begin
               r = raise_error(nsdf_pkg::ERR_ZERO, e);
               return 1'b1;
            end
            r = raise_error(nsdf_pkg::ERR_BADCHAR, e);
            return 1'b1;
         end
      endcase
   endfunction

   // Offers one word and waits until it is taken. A typed row overrides the
   // result that the decoder works out, while the decoder still advances.
   task automatic send_word(input logic [7:0] b, input logic e,
                            input bit use_typed = 1'b0, input bit typed_has = 1'b0,
                            input nsdf_pkg::nsdf_result_type typed_result = '0);
      nsdf_pkg::nsdf_result_type r;
      bit                        has_result;
      if (idle_allowed && $urandom_range(0, 79) == 0) begin
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      if (tx_idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_chunk_end <= e;
      // Inputs only move at rising edges, so the stall seen at the falling
      // edge is the one the next rising edge acts on.
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      has_result = decode_word(b, e, r);
      if (use_typed) begin
         has_result = typed_has;
         r = typed_result;
      end
      if (has_result) pending_results.push_back(r);
      sent_words++;
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      if (idx == nsdf_pkg::CSR_MODE) begin
         cfg_netstring = value[0];
         dec_phase = DEC_IDLE;
         dec_count = '0;
      end else begin
         cfg_max_length = value;
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // One netstring frame, a damaged frame, or a burst of noise.
   task automatic send_frame;
      logic [7:0]  bytes [$];
      int unsigned len;
      int unsigned header;
      int unsigned flavor;
      int unsigned pick;
      string       digits;
      flavor = $urandom_range(0, 9);
      if ($urandom_range(0, 15) == 0) len = $urandom_range(1, 300);
      else len = $urandom_range(1, 8);
      if (len > cfg_max_length) len = $urandom_range(1, cfg_max_length);
      header = len;
      if (flavor == 9) begin
         repeat ($urandom_range(1, 6)) bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 2)) begin
            pick = $urandom_range(0, 3);
            bytes.push_back(pick == 0 ? nsdf_pkg::CH_SPACE : pick == 1 ? nsdf_pkg::CH_TAB :
                            pick == 2 ? nsdf_pkg::CH_CR : nsdf_pkg::CH_LF);
         end
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) bytes.push_back(nsdf_pkg::CH_ZERO);
         end
         if (flavor == 8) begin
            pick = $urandom_range(0, 2);
            if (pick == 0) header = cfg_max_length + 1 + $urandom_range(0, 3);
            else if (pick == 1) header = 0;
         end else begin
            pick = 3;
         end
         // A colon with no digits at all when pick is 2.
         if (pick != 2) begin
            digits = $sformatf("%0d", header);
            for (int i = 0; i < digits.len(); i++) bytes.push_back(digits[i]);
         end
         bytes.push_back(nsdf_pkg::CH_COLON);
         repeat (len) bytes.push_back(8'($urandom_range(0, 255)));
         bytes.push_back(nsdf_pkg::CH_COMMA);
         if (flavor == 7) bytes[$urandom_range(0, bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end
      for (int i = 0; i < bytes.size(); i++) begin
         send_word(bytes[i], ($urandom_range(0, 7) == 0) ||
                   (flavor >= 7 && i == bytes.size() - 1));
      end
   endtask

   task automatic run_netstring(input int unsigned target);
      int unsigned stop_at;
      stop_at = sent_words + target;
      while (sent_words < stop_at) send_frame();
      drain_results();
   endtask

   task automatic run_raw(input int unsigned target);
      repeat (target) send_word(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      drain_results();
   endtask

   // Receiver: random stall bursts, plus a long hold whenever one is requested.
   initial begin : receiver
      int unsigned holds_served;
      int unsigned hold_left;
      int unsigned burst_left;
      holds_served = 0;
      hold_left = 0;
      burst_left = 0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rx_idle_on && burst_left != 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(0, 11);
            rsp_stall <= 1'b1;
         end else begin
            burst_left = 0;
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(input bit had_expected,
                                  input nsdf_pkg::nsdf_result_type want,
                                  input nsdf_pkg::nsdf_result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         if (had_expected)
            $display("mismatch at cycle %0d: ", cycle_count,
                     "expected kind=%0d payload=%02h last=%0b code=%0d, ",
                     want.kind, want.payload, want.last, want.error_code,
                     "got kind=%0d payload=%02h last=%0b code=%0d",
                     got.kind, got.payload, got.last, got.error_code);
         else
            $display("mismatch at cycle %0d: no result expected, ", cycle_count,
                     "got kind=%0d payload=%02h last=%0b code=%0d",
                     got.kind, got.payload, got.last, got.error_code);
      end
   endtask

   // Outputs are stable by the falling edge; a word seen here is taken at
   // the next rising edge because the stall only moves at rising edges.
   always @(negedge clock) begin
      nsdf_pkg::nsdf_result_type got;
      nsdf_pkg::nsdf_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_kind;
         got.payload = rsp_payload;
         got.last = rsp_last;
         got.error_code = rsp_error_code;
         if (pending_results.size() == 0) begin
            report_mismatch(1'b0, NO_RESULT, got);
         end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.payload !== want.payload ||
                got.last !== want.last || got.error_code !== want.error_code)
               report_mismatch(1'b1, want, got);
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_word(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].chunk_end,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].has_result,
                   DIRECTED_ROWS[i].result);
      end
      drain_results();

      write_reg(nsdf_pkg::CSR_MAX_LEN, 16'hffff);
      run_netstring(350);

      write_reg(nsdf_pkg::CSR_MAX_LEN, 16'd1);
      run_netstring(150);

      // Raw mode with a long receiver hold so the output side backs up.
      write_reg(nsdf_pkg::CSR_MODE, 16'd0);
      tx_idle_on = 1'b0;
      hold_requests++;
      run_raw(250);

      write_reg(nsdf_pkg::CSR_MODE, 16'd1);
      write_reg(nsdf_pkg::CSR_MAX_LEN, 16'd9);
      run_netstring(250);

      write_reg(nsdf_pkg::CSR_MAX_LEN, 16'd100);
      run_netstring(300);

      write_reg(nsdf_pkg::CSR_MAX_LEN, 16'($urandom_range(1, 65535)));
      idle_allowed = 1'b0;
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      run_netstring(300);

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("netstring_deframer_core_tb: PASS");
      end else begin
         $display("netstring_deframer_core_tb: FAIL");
      end
      $finish;
   end

endmodule
